FILE: hdl/refcounted_page_alias_table_assert.svh
// assertion macros for the page alias table
`ifndef REFCOUNTED_PAGE_ALIAS_TABLE_ASSERT_SVH
`define REFCOUNTED_PAGE_ALIAS_TABLE_ASSERT_SVH
`ifndef ASSERT_OFF
`define RPAT_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define RPAT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define RPAT_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define RPAT_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

FILE: hdl/rpat_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpat_pkg
// shared types and codes of the reference counted page alias table
// ----------------------------------------------------------------------------
package rpat_pkg;

   localparam logic [1:0] ACT_PUT  = 2'd0;
   localparam logic [1:0] ACT_DEL  = 2'd1;
   localparam logic [1:0] ACT_REF  = 2'd2;
   localparam logic [1:0] ACT_NONE = 2'd3;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_MISSING = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;
   localparam logic [1:0] ST_NODEL   = 2'd3;

   localparam logic [8:0] COUNT_MAX = 9'd511;

   typedef struct packed {
      logic [1:0]  action;
      logic [63:0] page_key;
      logic [63:0] alias_key;
      logic [63:0] entry_data;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [63:0] real_page;
      logic [8:0]  count_after;
      logic        page_freed;
   } rsp_type;

   typedef struct packed {
      logic        valid;
      logic [63:0] key;
      logic [63:0] target;
   } alias_slot_type;

   typedef struct packed {
      logic        valid;
      logic [63:0] page;
      logic [63:0] entry;
      logic [8:0]  count;
   } page_slot_type;

endpackage

FILE: hdl/rpat_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpat_ram
// simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module rpat_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: hdl/refcounted_page_alias_table.sv
`timescale 1ns / 1ps
// Operation: each table scan reads every slot of that table in turn; put and delete scan
//   the alias and page tables and commit; ref scans up to four times, releases and
//   commits.
// One item at a time: the next is taken only back in idle, after the commit; the scans of
//   the single read port memories keep one item in flight. Reset: a clearing pass over
//   max(ALIAS_SLOTS, PAGE_SLOTS) slots runs after reset, during which no item is taken.
// ----------------------------------------------------------------------------
// refcounted_page_alias_table
// alias table and reference counted page table kept in two rams
// ----------------------------------------------------------------------------
`include "refcounted_page_alias_table_assert.svh"
module refcounted_page_alias_table
   import rpat_pkg::*;
#(
   parameter int ALIAS_SLOTS = 256,
   parameter int PAGE_SLOTS  = 256
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int AAW  = $clog2(ALIAS_SLOTS);
   localparam int PAW  = $clog2(PAGE_SLOTS);
   localparam int MAXS = (ALIAS_SLOTS > PAGE_SLOTS) ? ALIAS_SLOTS : PAGE_SLOTS;
   localparam int CW   = $clog2(MAXS + 1);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_ALIAS1, S_PAGE1, S_ALIAS2, S_PAGE2, S_REL, S_COMMIT
   } state_type;

   state_type state_ff;
   logic [CW-1:0] scan_ff;
   logic          pend_ff;
   logic [CW-1:0] ridx_ff;
   logic [63:0]   skey_ff;
   req_type       req_ff;
   logic [63:0]   real_ff;
   logic          freed_ff;

   logic           a_hit_ff, a_free_ff;
   logic [AAW-1:0] a_idx_ff, a_fidx_ff;
   logic [63:0]    a_tgt_ff;
   logic           p_hit_ff, p_free_ff;
   logic [PAW-1:0] p_idx_ff, p_fidx_ff;
   page_slot_type  p_slot_ff;
   logic           q_hit_ff;
   logic [PAW-1:0] q_idx_ff;
   page_slot_type  q_slot_ff;

   logic           rsp_valid_ff;
   rsp_type        rsp_data_ff;

   logic           a_we, p_we;
   logic [AAW-1:0] a_waddr;
   logic [PAW-1:0] p_waddr;
   alias_slot_type a_wdata, a_rdata;
   page_slot_type  p_wdata, p_rdata;

   logic    alias_scan, page_scan, issue, scan_done, commit_go, same;
   rsp_type rsp_in;

   // scan control
   assign alias_scan = (state_ff == S_ALIAS1) || (state_ff == S_ALIAS2);
   assign page_scan  = (state_ff == S_PAGE1) || (state_ff == S_PAGE2);
   assign issue      = alias_scan ? (scan_ff < CW'(ALIAS_SLOTS)) : (scan_ff < CW'(PAGE_SLOTS));
   assign scan_done  = !issue && !pend_ff;
   assign commit_go  = !rsp_valid_ff || !rsp_stall;
   assign same       = a_hit_ff && (a_tgt_ff == real_ff);

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // memories
   rpat_ram #(.WIDTH($bits(alias_slot_type)), .DEPTH(ALIAS_SLOTS)) u_alias_ram (
      .clock(clock), .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
      .raddr(scan_ff[AAW-1:0]), .rdata(a_rdata)
   );

   rpat_ram #(.WIDTH($bits(page_slot_type)), .DEPTH(PAGE_SLOTS)) u_page_ram (
      .clock(clock), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
      .raddr(scan_ff[PAW-1:0]), .rdata(p_rdata)
   );

   // writebacks and result of the commit
   always_comb begin
      a_we    = 1'b0;
      a_waddr = scan_ff[AAW-1:0];
      a_wdata = '0;
      p_we    = 1'b0;
      p_waddr = scan_ff[PAW-1:0];
      p_wdata = '0;
      rsp_in  = '0;
      rsp_in.real_page  = real_ff;
      rsp_in.page_freed = freed_ff;
      unique case (state_ff)
         S_CLEAR: begin
            a_we = (scan_ff < CW'(ALIAS_SLOTS));
            p_we = (scan_ff < CW'(PAGE_SLOTS));
         end
         S_REL: begin
            p_waddr = q_idx_ff;
            p_we    = q_hit_ff;
            p_wdata = q_slot_ff;
            if (q_slot_ff.count <= 9'd1) begin
               p_wdata = '0;
            end else begin
               p_wdata.count = q_slot_ff.count - 9'd1;
            end
         end
         S_COMMIT: begin
            unique case (req_ff.action)
               ACT_PUT: begin
                  if ((!p_hit_ff && !p_free_ff) || (!a_hit_ff && !a_free_ff)) begin
                     rsp_in.status      = ST_FULL;
                     rsp_in.count_after = p_hit_ff ? p_slot_ff.count : 9'd0;
                  end else begin
                     p_we          = commit_go;
                     p_waddr       = p_hit_ff ? p_idx_ff : p_fidx_ff;
                     p_wdata.valid = 1'b1;
                     p_wdata.page  = real_ff;
                     p_wdata.entry = req_ff.entry_data;
                     p_wdata.count = p_hit_ff ? p_slot_ff.count : 9'd1;
                     a_we          = commit_go && !a_hit_ff;
                     a_waddr       = a_fidx_ff;
                     a_wdata       = '{valid: 1'b1, key: req_ff.page_key, target: real_ff};
                     rsp_in.count_after = p_wdata.count;
                  end
               end
               ACT_DEL: begin
                  a_we    = commit_go && a_hit_ff;
                  a_waddr = a_idx_ff;
                  if (!p_hit_ff) begin
                     rsp_in.status = ST_NODEL;
                  end else begin
                     p_we    = commit_go;
                     p_waddr = p_idx_ff;
                     p_wdata = p_slot_ff;
                     if (p_slot_ff.count <= 9'd1) begin
                        p_wdata           = '0;
                        rsp_in.page_freed = 1'b1;
                     end else begin
                        p_wdata.count = p_slot_ff.count - 9'd1;
                     end
                     rsp_in.count_after = p_wdata.count;
                  end
               end
               ACT_REF: begin
                  if (!p_hit_ff) begin
                     rsp_in.status = ST_MISSING;
                  end else if (!a_hit_ff && !a_free_ff) begin
                     rsp_in.status      = ST_FULL;
                     rsp_in.count_after = p_slot_ff.count;
                  end else begin
                     a_we    = commit_go;
                     a_waddr = a_hit_ff ? a_idx_ff : a_fidx_ff;
                     a_wdata = '{valid: 1'b1, key: req_ff.alias_key, target: real_ff};
                     p_waddr = p_idx_ff;
                     p_wdata = p_slot_ff;
                     if (!same && (p_slot_ff.count != COUNT_MAX)) begin
                        p_we          = commit_go;
                        p_wdata.count = p_slot_ff.count + 9'd1;
                     end
                     rsp_in.count_after = p_wdata.count;
                  end
               end
               default: begin
                  rsp_in = '0;
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   // sequencer, scan bookkeeping and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         scan_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && !((state_ff == S_COMMIT) && commit_go)) begin
            rsp_valid_ff <= 1'b0;
         end
         // record the beat read in the previous cycle
         pend_ff <= (alias_scan || page_scan) && issue;
         ridx_ff <= scan_ff;
         if (pend_ff && alias_scan) begin
            if (a_rdata.valid && (a_rdata.key == skey_ff) && !a_hit_ff) begin
               a_hit_ff <= 1'b1;
               a_idx_ff <= ridx_ff[AAW-1:0];
               a_tgt_ff <= a_rdata.target;
            end
            if (!a_rdata.valid && !a_free_ff) begin
               a_free_ff <= 1'b1;
               a_fidx_ff <= ridx_ff[AAW-1:0];
            end
         end
         if (pend_ff && (state_ff == S_PAGE1)) begin
            if (p_rdata.valid && (p_rdata.page == skey_ff) && !p_hit_ff) begin
               p_hit_ff  <= 1'b1;
               p_idx_ff  <= ridx_ff[PAW-1:0];
               p_slot_ff <= p_rdata;
            end
            if (!p_rdata.valid && !p_free_ff) begin
               p_free_ff <= 1'b1;
               p_fidx_ff <= ridx_ff[PAW-1:0];
            end
         end
         if (pend_ff && (state_ff == S_PAGE2)) begin
            if (p_rdata.valid && (p_rdata.page == skey_ff) && !q_hit_ff) begin
               q_hit_ff  <= 1'b1;
               q_idx_ff  <= ridx_ff[PAW-1:0];
               q_slot_ff <= p_rdata;
            end
         end
         if ((alias_scan || page_scan) && issue) begin
            scan_ff <= scan_ff + CW'(1);
         end
         unique case (state_ff)
            S_CLEAR: begin
               scan_ff <= scan_ff + CW'(1);
               if (scan_ff == CW'(MAXS - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_valid) begin
                  req_ff    <= req_data;
                  skey_ff   <= req_data.page_key;
                  freed_ff  <= 1'b0;
                  scan_ff   <= '0;
                  a_hit_ff  <= 1'b0;
                  a_free_ff <= 1'b0;
                  real_ff   <= '0;
                  if ((req_data.action == ACT_PUT) || (req_data.action == ACT_DEL)
                      || (req_data.action == ACT_REF)) begin
                     state_ff <= S_ALIAS1;
                  end else begin
                     p_hit_ff <= 1'b0;
                     state_ff <= S_COMMIT;
                  end
               end
            end
            S_ALIAS1: begin
               if (scan_done) begin
                  real_ff   <= a_hit_ff ? a_tgt_ff : skey_ff;
                  skey_ff   <= a_hit_ff ? a_tgt_ff : skey_ff;
                  scan_ff   <= '0;
                  p_hit_ff  <= 1'b0;
                  p_free_ff <= 1'b0;
                  state_ff  <= S_PAGE1;
               end
            end
            S_PAGE1: begin
               if (scan_done) begin
                  scan_ff <= '0;
                  if ((req_ff.action == ACT_REF) && p_hit_ff) begin
                     skey_ff   <= req_ff.alias_key;
                     a_hit_ff  <= 1'b0;
                     a_free_ff <= 1'b0;
                     state_ff  <= S_ALIAS2;
                  end else begin
                     state_ff <= S_COMMIT;
                  end
               end
            end
            S_ALIAS2: begin
               if (scan_done) begin
                  scan_ff <= '0;
                  if (a_hit_ff && (a_tgt_ff != real_ff)) begin
                     skey_ff  <= a_tgt_ff;
                     q_hit_ff <= 1'b0;
                     state_ff <= S_PAGE2;
                  end else begin
                     state_ff <= S_COMMIT;
                  end
               end
            end
            S_PAGE2: begin
               if (scan_done) begin
                  state_ff <= S_REL;
               end
            end
            S_REL: begin
               freed_ff <= q_hit_ff && (q_slot_ff.count <= 9'd1);
               state_ff <= S_COMMIT;
            end
            S_COMMIT: begin
               if (commit_go) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= rsp_in;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // checks
   `RPAT_ASSERT_IMPLY(a_pend_in_scan, clock, reset, pend_ff, alias_scan || page_scan, "read beat outside a scan")
   `RPAT_ASSERT_IMPLY(a_scan_bound, clock, reset, alias_scan || page_scan, scan_ff <= CW'(MAXS), "scan counter overrun")
   `RPAT_ASSERT_IMPLY(a_nodel_zero, clock, reset, rsp_valid_ff && (rsp_data_ff.status == ST_NODEL), (rsp_data_ff.count_after == 9'd0) && !rsp_data_ff.page_freed, "nothing deleted with count")
   `RPAT_ASSERT_NEXT(a_commit_load, clock, reset, (state_ff == S_COMMIT) && commit_go, rsp_valid_ff && (state_ff == S_IDLE), "commit did not load result")

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the reference counted page alias table.
// A scoreboard keeps its own copy of both tables and works out the result of
// every accepted request beat. Result beats are compared with the oldest
// pending outcome, field by field. Traffic is a short directed run, then random
// put/delete/ref traffic: one phase on a small key pool, one that fills both
// tables with fresh keys, and one that mixes the two. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_top;
   import rpat_pkg::*;

   localparam int ALIAS_N = 256;
   localparam int PAGE_N  = 256;
   localparam int POOL_N  = 12;

   // table shadow and queue of pending outcomes
   class alias_table_scoreboard;
      alias_slot_type aliases[ALIAS_N];
      page_slot_type  pages[PAGE_N];
      rsp_type        outcome_q[$];
      int             errors;
      int             seen[4];

      function new();
         foreach (aliases[i]) aliases[i] = '0;
         foreach (pages[i]) pages[i] = '0;
         errors = 0;
         foreach (seen[i]) seen[i] = 0;
      endfunction

      function int find_alias(logic [63:0] key);
         foreach (aliases[i])
            if (aliases[i].valid && aliases[i].key == key) return i;
         return -1;
      endfunction

      function int free_alias();
         foreach (aliases[i]) if (!aliases[i].valid) return i;
         return -1;
      endfunction

      function int find_page(logic [63:0] pg);
         foreach (pages[i]) if (pages[i].valid && pages[i].page == pg) return i;
         return -1;
      endfunction

      function int free_page();
         foreach (pages[i]) if (!pages[i].valid) return i;
         return -1;
      endfunction

      // drop one reference, report whether the page went away
      function bit drop_ref(logic [63:0] pg);
         int p;
         p = find_page(pg);
         if (p < 0) return 0;
         if (pages[p].count <= 9'd1) begin
            pages[p].valid = 0;
            pages[p].count = '0;
            return 1;
         end
         pages[p].count = pages[p].count - 9'd1;
         return 0;
      endfunction

      // apply one accepted request to the shadow tables
      function void note_request(req_type rq);
         rsp_type r;
         int a, p, np, na, old;
         bit same;
         r = '0;
         r.status = ST_OK;
         case (rq.action)
            ACT_PUT: begin
               a = find_alias(rq.page_key);
               r.real_page = (a >= 0) ? aliases[a].target : rq.page_key;
               p = find_page(r.real_page);
               np = (p >= 0) ? p : free_page();
               na = (a >= 0) ? a : free_alias();
               if (np < 0 || na < 0) begin
                  r.status = ST_FULL;
                  r.count_after = (p >= 0) ? pages[p].count : '0;
               end else begin
                  if (p < 0) begin
                     pages[np].valid = 1;
                     pages[np].page = r.real_page;
                     pages[np].count = 9'd1;
                  end
                  pages[np].entry = rq.entry_data;
                  if (a < 0) begin
                     aliases[na].valid = 1;
                     aliases[na].key = rq.page_key;
                     aliases[na].target = r.real_page;
                  end
                  r.count_after = pages[np].count;
               end
            end
            ACT_DEL: begin
               a = find_alias(rq.page_key);
               r.real_page = (a >= 0) ? aliases[a].target : rq.page_key;
               if (a >= 0) aliases[a].valid = 0;
               p = find_page(r.real_page);
               if (p < 0) r.status = ST_NODEL;
               else begin
                  r.page_freed = drop_ref(r.real_page);
                  r.count_after = pages[p].valid ? pages[p].count : '0;
               end
            end
            ACT_REF: begin
               a = find_alias(rq.page_key);
               r.real_page = (a >= 0) ? aliases[a].target : rq.page_key;
               p = find_page(r.real_page);
               if (p < 0) r.status = ST_MISSING;
               else begin
                  old = find_alias(rq.alias_key);
                  na = (old >= 0) ? old : free_alias();
                  if (na < 0) begin
                     r.status = ST_FULL;
                     r.count_after = pages[p].count;
                  end else begin
                     same = (old >= 0) && (aliases[old].target == r.real_page);
                     if (old >= 0 && !same) r.page_freed = drop_ref(aliases[old].target);
                     aliases[na].valid = 1;
                     aliases[na].key = rq.alias_key;
                     aliases[na].target = r.real_page;
                     if (!same && pages[p].count < COUNT_MAX)
                        pages[p].count = pages[p].count + 9'd1;
                     r.count_after = pages[p].count;
                  end
               end
            end
            default: r = '0;
         endcase
         outcome_q.push_back(r);
      endfunction

      // compare one result beat with the oldest outcome
      function void check_result(rsp_type got);
         rsp_type w;
         if (outcome_q.size() == 0) begin
            $display("%0t: unexpected result beat %h", $time, got);
            errors++;
            return;
         end
         w = outcome_q.pop_front();
         seen[w.status]++;
         if (got.status !== w.status) begin
            $display("%0t: status exp %0d got %0d", $time, w.status, got.status);
            errors++;
         end
         if (got.real_page !== w.real_page) begin
            $display("%0t: real_page exp %h got %h", $time, w.real_page, got.real_page);
            errors++;
         end
         if (got.count_after !== w.count_after) begin
            $display("%0t: count_after exp %0d got %0d", $time, w.count_after,
                     got.count_after);
            errors++;
         end
         if (got.page_freed !== w.page_freed) begin
            $display("%0t: page_freed exp %0d got %0d", $time, w.page_freed,
                     got.page_freed);
            errors++;
         end
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   alias_table_scoreboard sb;
   logic [63:0] key_pool[POOL_N];
   bit quiet;
   bit hold_go;
   int hold_left;
   int sent;

   refcounted_page_alias_table dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   // clock
   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // run limit
   initial begin
      #60000000;
      $display("end of test: mismatches");
      $finish;
   end

   // result side: check beats, random stall, one long hold-off
   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall) sb.check_result(rsp_data);
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left = hold_left - 1;
      end else if (hold_go) begin
         hold_go = 0;
         hold_left = 3000;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !quiet && ($urandom_range(99) < 38);
      end
   end

   function automatic logic [63:0] rnd64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [63:0] pick_key(int fresh_pct);
      if ($urandom_range(99) < fresh_pct) return rnd64();
      return key_pool[$urandom_range(POOL_N - 1)];
   endfunction

   // send one request beat, at random with an idle gap before it
   task automatic send_req(logic [1:0] act, logic [63:0] k, logic [63:0] ak,
                           logic [63:0] d);
      req_type rq;
      rq.action = act;
      rq.page_key = k;
      rq.alias_key = ak;
      rq.entry_data = d;
      if (!quiet && $urandom_range(99) < 38) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= rq;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(rq);
      sent++;
   endtask

   task automatic send_random(int fresh_pct);
      int roll;
      logic [1:0] act;
      roll = $urandom_range(99);
      if (roll < 40) act = ACT_PUT;
      else if (roll < 65) act = ACT_DEL;
      else if (roll < 95) act = ACT_REF;
      else act = ACT_NONE;
      send_req(act, pick_key(fresh_pct), pick_key(fresh_pct), rnd64());
   endtask

   initial begin
      sb = new();
      sent = 0;
      quiet = 0;
      hold_go = 0;
      hold_left = 0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      rsp_stall <= 1'b0;
      foreach (key_pool[i]) key_pool[i] = rnd64();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: field extremes and each special case
      send_req(ACT_PUT, key_pool[0], '0, '1);
      send_req(ACT_PUT, '1, '1, '0);
      send_req(ACT_PUT, '0, '0, 64'h5a5a_a5a5_0f0f_f0f0);
      send_req(ACT_PUT, key_pool[0], '0, 64'h1234);       // existing page keeps count
      send_req(ACT_REF, key_pool[1], key_pool[2], '0);    // target missing
      send_req(ACT_REF, key_pool[0], key_pool[1], '0);    // new alias
      send_req(ACT_REF, '0, key_pool[1], '1);             // rebind, drops a ref of old page
      send_req(ACT_REF, '0, key_pool[1], '0);             // same target, count kept
      send_req(ACT_REF, key_pool[1], key_pool[3], '0);    // target through an alias
      send_req(ACT_DEL, key_pool[1], '1, '1);             // drops alias
      send_req(ACT_DEL, key_pool[1], '0, '0);             // nothing deleted
      send_req(ACT_DEL, key_pool[0], '0, '0);             // last ref, freed
      send_req(ACT_DEL, '1, '0, '0);
      send_req(ACT_DEL, '0, '0, '0);
      send_req(ACT_DEL, '0, '0, '0);
      send_req(ACT_NONE, '1, '1, '1);                     // unused action code
      send_req(ACT_PUT, key_pool[3], key_pool[4], '1);    // put through an alias
      send_req(ACT_DEL, rnd64(), '0, '0);                 // absent key

      // pool phase with a long result hold-off
      for (int i = 0; i < 500; i++) begin
         if (i == 200) hold_go = 1;
         send_random(10);
      end
      // sender drains before the fill phase
      req_valid <= 1'b0;
      while (sb.outcome_q.size() != 0) @(posedge clock);
      // fill both tables with fresh keys
      for (int i = 0; i < 400; i++) begin
         if ($urandom_range(99) < 75) send_req(ACT_PUT, rnd64(), rnd64(), rnd64());
         else send_random(50);
      end
      // mixed phase, with a stretch of no idling on either side
      for (int i = 0; i < 750; i++) begin
         quiet = (i >= 200 && i < 350);
         send_random(35);
      end
      quiet = 0;
      req_valid <= 1'b0;

      while (sb.outcome_q.size() != 0) @(posedge clock);
      repeat (2100) @(posedge clock);
      $display("covered %0d requests: %0d ok, %0d missing target, %0d full, %0d nothing deleted",
               sent, sb.seen[ST_OK], sb.seen[ST_MISSING], sb.seen[ST_FULL],
               sb.seen[ST_NODEL]);
      if (sb.errors == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end
endmodule
